@@ hw/rtl/srrc_pkg.sv @@
package srrc_pkg;

  // field widths
  localparam int SPEED_W    = 24;
  localparam int RATE_W     = 15;
  localparam int PER_W      = 20;
  localparam int DT_W       = 20;
  localparam int ACC_W      = 16;
  localparam int MS_W       = 3;
  localparam int REQ_W      = 2;
  localparam int FRAC_W     = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // ramp limit: accel * dt * 256 / 1e6 stays below 2^25
  localparam int LIM_W      = 25;
  localparam int SLEW_W     = LIM_W + 1;
  localparam int MUL_W      = ACC_W + DT_W;
  localparam int MUL_CNT_W  = $clog2(DT_W + 1);
  localparam int DIV_NUM_W  = MUL_W + FRAC_W;
  localparam int DIV_DEN_W  = 20;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

  localparam int unsigned TICK_RATE_HZ_DEF = 1000000;

  localparam logic [DIV_DEN_W-1:0]     LIM_DIVISOR = DIV_DEN_W'(1000000);
  localparam logic signed [SLEW_W-1:0] SPEED_LIMIT = SLEW_W'(8388352);
  localparam logic [PER_W-1:0]         PERIOD_MAX  = '1;
  localparam logic [MS_W-1:0]          MS_MAX      = MS_W'(5);

  localparam logic [RATE_W-1:0] MAX_RATE_RST  = RATE_W'(1000);
  localparam logic [RATE_W-1:0] MIN_RATE_RST  = RATE_W'(10);
  localparam logic [ACC_W-1:0]  ACCEL_RST     = ACC_W'(2000);
  localparam logic [MS_W-1:0]   MICROSTEP_RST = MS_W'(4);

  typedef enum logic [REQ_W-1:0] {
    REQ_UPDATE = 2'd0,
    REQ_START  = 2'd1,
    REQ_STOP   = 2'd2
  } req_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_RATE  = 2'd0,
    CFG_MIN_RATE  = 2'd1,
    CFG_ACCEL     = 2'd2,
    CFG_MICROSTEP = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIVL,
    ST_SLEW,
    ST_APPLY,
    ST_RATE,
    ST_DIVP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] iters;
  } div_cmd_t;

endpackage

@@ hw/rtl/srrc_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
module srrc_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [srrc_pkg::ACC_W-1:0]  a_i,
  input  logic [srrc_pkg::DT_W-1:0]   b_i,
  output logic                        done_o,
  output logic [srrc_pkg::MUL_W-1:0]  prod_o
);

  logic [srrc_pkg::ACC_W-1:0]     a_q;
  logic [srrc_pkg::MUL_W-1:0]     prod_q, prod_d;
  logic [srrc_pkg::ACC_W:0]       sum;
  logic [srrc_pkg::MUL_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;

  // high half accumulates, low half holds the remaining multiplier bits
  always_comb begin
    sum    = {1'b0, prod_q[srrc_pkg::MUL_W-1:srrc_pkg::DT_W]}
           + (prod_q[0] ? {1'b0, a_q} : '0);
    prod_d = {sum, prod_q[srrc_pkg::DT_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= srrc_pkg::MUL_CNT_W'(srrc_pkg::DT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == srrc_pkg::MUL_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      prod_q <= {{srrc_pkg::ACC_W{1'b0}}, b_i};
    end else if (busy_q) begin
      prod_q <= prod_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

@@ hw/rtl/srrc_div.sv @@
// Restoring divider, one quotient bit per cycle, dividend consumed MSB first.
// The dividend is left-aligned; iters sets how many of its bits are used.
module srrc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  srrc_pkg::div_cmd_t              cmd_i,
  input  logic [srrc_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [srrc_pkg::DIV_DEN_W-1:0]  den_i,
  output logic                            done_o,
  output logic [srrc_pkg::DIV_NUM_W-1:0]  quot_o
);

  logic [srrc_pkg::DIV_NUM_W-1:0] num_q;
  logic [srrc_pkg::DIV_NUM_W-1:0] quot_q;
  logic [srrc_pkg::DIV_DEN_W-1:0] den_q;
  logic [srrc_pkg::DIV_DEN_W-1:0] rem_q, rem_d;
  logic [srrc_pkg::DIV_DEN_W:0]   trial, diff;
  logic                           ge;
  logic [srrc_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;

  // remainder stays below the divisor, so the difference fits its width
  always_comb begin
    trial = {rem_q, num_q[srrc_pkg::DIV_NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? diff[srrc_pkg::DIV_DEN_W-1:0] : trial[srrc_pkg::DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == srrc_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[srrc_pkg::DIV_NUM_W-2:0], 1'b0};
      rem_q  <= rem_d;
      quot_q <= {quot_q[srrc_pkg::DIV_NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ hw/rtl/stepper_rate_ramp_controller.sv @@
// Start, stop and rejected items go straight to ST_FINISH and then into the output register.
// Update items run a serial multiply of accel by elapsed_us, a serial divide for the ramp limit,
// the slew, apply and rate steps, and a serial divide for the step period, which is skipped when
// the clamped step rate is zero; the result then waits in ST_FINISH for the output register.
// One item in flight at a time; the next item is taken while a result waits.
// Async active-low reset: registers to defaults, speed zero, controller stopped.
module stepper_rate_ramp_controller #(
  parameter int unsigned TICK_RATE_HZ = srrc_pkg::TICK_RATE_HZ_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [srrc_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [srrc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [47:0]                     s_axis_tdata_i,  // target_speed_q8, elapsed_us
  input  logic [srrc_pkg::REQ_W-1:0]      s_axis_tuser_i,  // req_type
  // result items
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // speed_now_q8, step_rate, step_period, direction, direction_written, pulses_running
  output logic [63:0]                     m_axis_tdata_o,
  output logic                            m_axis_tuser_o   // status
);

  localparam int TICK_W = $clog2(TICK_RATE_HZ + 1);
  localparam logic [srrc_pkg::DIV_NUM_W-1:0] TICK_NUM =
    (srrc_pkg::DIV_NUM_W)'(TICK_RATE_HZ) << (srrc_pkg::DIV_NUM_W - TICK_W);
  localparam logic [srrc_pkg::DIV_CNT_W-1:0] TICK_ITERS = (srrc_pkg::DIV_CNT_W)'(TICK_W);
  localparam logic [srrc_pkg::DIV_CNT_W-1:0] LIM_ITERS =
    (srrc_pkg::DIV_CNT_W)'(srrc_pkg::DIV_NUM_W);

  localparam int SW = srrc_pkg::SLEW_W;

  srrc_pkg::state_e state_q, state_d;

  // config
  logic [srrc_pkg::RATE_W-1:0] max_rate_q, min_rate_q;
  logic [srrc_pkg::ACC_W-1:0]  accel_q;
  logic [srrc_pkg::MS_W-1:0]   ms_q;

  // controller state
  logic signed [srrc_pkg::SPEED_W-1:0] speed_q;
  logic dir_level_q, dir_known_q, pulse_q, running_q;

  // per-item work registers
  logic [srrc_pkg::SPEED_W-1:0]       tgt_q;
  logic [srrc_pkg::LIM_W-1:0]         lim_q;
  logic signed [srrc_pkg::LIM_W-1:0]  dcl_q;
  logic                               res_status_q, res_written_q;
  logic [srrc_pkg::RATE_W-1:0]        res_rate_q;
  logic [srrc_pkg::PER_W-1:0]         res_period_q;

  // output register
  logic                               out_valid_q;
  logic                               out_status_q, out_dir_q, out_written_q, out_pulse_q;
  logic [srrc_pkg::SPEED_W-1:0]       out_speed_q;
  logic [srrc_pkg::RATE_W-1:0]        out_rate_q;
  logic [srrc_pkg::PER_W-1:0]         out_period_q;

  logic                               accept, out_load, mul_start, mul_done, div_done;
  srrc_pkg::div_cmd_t                 div_cmd;
  srrc_pkg::req_e                     req_c;
  logic [srrc_pkg::MUL_W-1:0]         mul_prod;
  logic [srrc_pkg::DIV_NUM_W-1:0]     div_num, div_quot;
  logic [srrc_pkg::DIV_DEN_W-1:0]     div_den;

  logic signed [SW-1:0]               tgt_x, spd_x, delta, lim_x, nlim_x, slew_c, sum_c;
  logic signed [srrc_pkg::SPEED_W-1:0] speed_sat;
  logic [srrc_pkg::SPEED_W-1:0]       speed_abs;
  logic [srrc_pkg::RATE_W-1:0]        mag, rate_clamp, rate_c;
  logic [srrc_pkg::MS_W-1:0]          sh;
  logic [srrc_pkg::DIV_DEN_W-1:0]     freq;
  logic [srrc_pkg::PER_W-1:0]         period_c;
  logic                               want_dir;

  assign req_c = srrc_pkg::req_e'(s_axis_tuser_i);

  // ---------------- arithmetic ----------------
  always_comb begin
    tgt_x  = {{(SW - srrc_pkg::SPEED_W){tgt_q[srrc_pkg::SPEED_W-1]}}, tgt_q};
    spd_x  = {{(SW - srrc_pkg::SPEED_W){speed_q[srrc_pkg::SPEED_W-1]}}, speed_q};
    delta  = tgt_x - spd_x;
    lim_x  = {1'b0, lim_q};
    nlim_x = -lim_x;
    if (delta > lim_x)       slew_c = lim_x;
    else if (delta < nlim_x) slew_c = nlim_x;
    else                     slew_c = delta;

    sum_c = spd_x + {dcl_q[srrc_pkg::LIM_W-1], dcl_q};
    if (sum_c > srrc_pkg::SPEED_LIMIT)       speed_sat = srrc_pkg::SPEED_W'(srrc_pkg::SPEED_LIMIT);
    else if (sum_c < -srrc_pkg::SPEED_LIMIT) speed_sat = srrc_pkg::SPEED_W'(-srrc_pkg::SPEED_LIMIT);
    else                                     speed_sat = sum_c[srrc_pkg::SPEED_W-1:0];

    // magnitude never exceeds 2^23, whole part is 15 bits
    want_dir   = speed_q[srrc_pkg::SPEED_W-1];
    speed_abs  = want_dir ? -speed_q : speed_q;
    mag        = speed_abs[srrc_pkg::FRAC_W +: srrc_pkg::RATE_W];
    rate_clamp = (mag > max_rate_q) ? max_rate_q : mag;
    rate_c     = (rate_clamp < min_rate_q) ? '0 : rate_clamp;
    sh         = (ms_q > srrc_pkg::MS_MAX) ? srrc_pkg::MS_MAX : ms_q;
    freq       = srrc_pkg::DIV_DEN_W'(rate_c) << sh;

    if (|div_quot[srrc_pkg::DIV_NUM_W-1:srrc_pkg::PER_W])
      period_c = srrc_pkg::PERIOD_MAX;
    else if (div_quot[srrc_pkg::PER_W-1:0] == '0)
      period_c = srrc_pkg::PER_W'(1);
    else
      period_c = div_quot[srrc_pkg::PER_W-1:0];
  end

  // divider is shared by the ramp limit and the step period
  always_comb begin
    if (state_q == srrc_pkg::ST_RATE) begin
      div_num = TICK_NUM;
      div_den = freq;
    end else begin
      div_num = {mul_prod, {srrc_pkg::FRAC_W{1'b0}}};
      div_den = srrc_pkg::LIM_DIVISOR;
    end
  end

  srrc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (accel_q),
    .b_i     (s_axis_tdata_i[srrc_pkg::SPEED_W +: srrc_pkg::DT_W]),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  srrc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= srrc_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d       = state_q;
    accept        = 1'b0;
    out_load      = 1'b0;
    mul_start     = 1'b0;
    div_cmd.start = 1'b0;
    div_cmd.iters = LIM_ITERS;
    unique case (state_q)
      srrc_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          accept = 1'b1;
          if (req_c == srrc_pkg::REQ_UPDATE && running_q) begin
            mul_start = 1'b1;
            state_d   = srrc_pkg::ST_MUL;
          end else begin
            state_d = srrc_pkg::ST_FINISH;
          end
        end
      end
      srrc_pkg::ST_MUL: begin
        if (mul_done) begin
          div_cmd.start = 1'b1;
          state_d       = srrc_pkg::ST_DIVL;
        end
      end
      srrc_pkg::ST_DIVL: begin
        if (div_done) state_d = srrc_pkg::ST_SLEW;
      end
      srrc_pkg::ST_SLEW:  state_d = srrc_pkg::ST_APPLY;
      srrc_pkg::ST_APPLY: state_d = srrc_pkg::ST_RATE;
      srrc_pkg::ST_RATE: begin
        if (rate_c != '0) begin
          div_cmd.start = 1'b1;
          div_cmd.iters = TICK_ITERS;
          state_d       = srrc_pkg::ST_DIVP;
        end else begin
          state_d = srrc_pkg::ST_FINISH;
        end
      end
      srrc_pkg::ST_DIVP: begin
        if (div_done) state_d = srrc_pkg::ST_FINISH;
      end
      srrc_pkg::ST_FINISH: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = srrc_pkg::ST_IDLE;
        end
      end
      default: state_d = srrc_pkg::ST_IDLE;
    endcase
  end

  // ---------------- config ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rate_q <= srrc_pkg::MAX_RATE_RST;
      min_rate_q <= srrc_pkg::MIN_RATE_RST;
      accel_q    <= srrc_pkg::ACCEL_RST;
      ms_q       <= srrc_pkg::MICROSTEP_RST;
    end else if (cfg_valid_i) begin
      unique case (srrc_pkg::cfg_e'(cfg_addr_i))
        srrc_pkg::CFG_MAX_RATE:  max_rate_q <= cfg_data_i[srrc_pkg::RATE_W-1:0];
        srrc_pkg::CFG_MIN_RATE:  min_rate_q <= cfg_data_i[srrc_pkg::RATE_W-1:0];
        srrc_pkg::CFG_ACCEL:     accel_q    <= cfg_data_i[srrc_pkg::ACC_W-1:0];
        srrc_pkg::CFG_MICROSTEP: ms_q       <= cfg_data_i[srrc_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // ---------------- controller state and item work ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q       <= '0;
      dir_level_q   <= 1'b0;
      dir_known_q   <= 1'b0;
      pulse_q       <= 1'b0;
      running_q     <= 1'b0;
      tgt_q         <= '0;
      lim_q         <= '0;
      dcl_q         <= '0;
      res_status_q  <= 1'b0;
      res_written_q <= 1'b0;
      res_rate_q    <= '0;
      res_period_q  <= '0;
    end else begin
      case (state_q)
        srrc_pkg::ST_IDLE: begin
          if (accept) begin
            tgt_q         <= s_axis_tdata_i[srrc_pkg::SPEED_W-1:0];
            res_status_q  <= 1'b0;
            res_written_q <= 1'b0;
            res_rate_q    <= '0;
            res_period_q  <= '0;
            case (req_c)
              srrc_pkg::REQ_START: begin
                if (running_q) res_status_q <= 1'b1;
                else           running_q    <= 1'b1;
              end
              srrc_pkg::REQ_STOP: begin
                if (running_q) begin
                  speed_q   <= '0;
                  pulse_q   <= 1'b0;
                  running_q <= 1'b0;
                end
              end
              srrc_pkg::REQ_UPDATE: begin
                if (!running_q) res_status_q <= 1'b1;
              end
              default: res_status_q <= 1'b1;
            endcase
          end
        end
        srrc_pkg::ST_DIVL: begin
          if (div_done) lim_q <= div_quot[srrc_pkg::LIM_W-1:0];
        end
        srrc_pkg::ST_SLEW:  dcl_q   <= slew_c[srrc_pkg::LIM_W-1:0];
        srrc_pkg::ST_APPLY: speed_q <= speed_sat;
        srrc_pkg::ST_RATE: begin
          res_rate_q <= rate_c;
          if (rate_c == '0) begin
            pulse_q <= 1'b0;
          end else if (!dir_known_q || dir_level_q != want_dir) begin
            // direction change or first move: pin written before pulses resume
            dir_level_q   <= want_dir;
            dir_known_q   <= 1'b1;
            res_written_q <= 1'b1;
          end
        end
        srrc_pkg::ST_DIVP: begin
          if (div_done) begin
            res_period_q <= period_c;
            pulse_q      <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_speed_q   <= speed_q;
      out_rate_q    <= res_rate_q;
      out_period_q  <= res_period_q;
      out_dir_q     <= dir_level_q;
      out_written_q <= res_written_q;
      out_pulse_q   <= pulse_q;
    end
  end

  assign s_axis_tready_o = (state_q == srrc_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {2'b00, out_pulse_q, out_written_q, out_dir_q,
                            out_period_q, out_rate_q, out_speed_q};

`ifndef SYNTHESIS
  a_pulse_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_q |-> running_q)
    else $error("pulse train active while controller stopped");

  a_pulse_needs_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_q |-> dir_known_q)
    else $error("pulses running before direction pin was written");

  a_stopped_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> speed_q == '0)
    else $error("nonzero speed while stopped");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |-> (out_rate_q == '0 && out_period_q == '0))
    else $error("rejected item carries a rate or period");

  a_period_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srrc_pkg::ST_DIVP && div_done) |=> (state_q == srrc_pkg::ST_FINISH && pulse_q))
    else $error("period result not taken");
`endif

endmodule

@@ sim/stepper_rate_ramp_controller_test.sv @@
module stepper_rate_ramp_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srrc_pkg::*;

  localparam int unsigned TICK_HZ = TICK_RATE_HZ_DEF;
  localparam logic [REQ_W-1:0] REQ_BAD = 2'd3;
  localparam longint SPD_SAT = 64'sd8388352;
  localparam longint PER_CAP = 64'sd1048575;
  localparam int unsigned MS_CAP = 5;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [SPEED_W-1:0] tgt;
    logic [DT_W-1:0]    dt;
  } ramp_req_t;

  typedef struct packed {
    logic               status;
    logic [SPEED_W-1:0] speed;
    logic [RATE_W-1:0]  rate;
    logic [PER_W-1:0]   period;
    logic               dir;
    logic               written;
    logic               pulses;
  } ramp_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [47:0]       s_axis_tdata_i = '0;  // target_speed_q8, elapsed_us
  logic [REQ_W-1:0]  s_axis_tuser_i = '0;  // req_type

  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // speed_now_q8, step_rate, step_period, direction, direction_written, pulses_running
  logic [63:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;  // status

  stepper_rate_ramp_controller #(
    .TICK_RATE_HZ(TICK_HZ)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #10 clk_i = ~clk_i;

  // shadow registers and motion state
  logic [RATE_W-1:0] cfg_max_rate = MAX_RATE_RST;
  logic [RATE_W-1:0] cfg_min_rate = MIN_RATE_RST;
  logic [ACC_W-1:0]  cfg_accel    = ACCEL_RST;
  logic [MS_W-1:0]   cfg_ms       = MICROSTEP_RST;
  longint spd = 0;
  logic   dir_lvl = 1'b0;
  logic   dir_ok = 1'b0;
  logic   pulse_on = 1'b0;
  logic   enabled = 1'b0;

  ramp_req_t    req_q[$];
  ramp_result_t ramp_exp_q[$];
  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  int in_gap = 0;
  int out_stall = 0;
  int idle_cycles = 0;
  logic in_busy;
  logic out_rdy;
  logic steady = 1'b0;
  ramp_req_t nxt;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    if (n_errors <= 40)
      $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
               n_results, what, got, want);
  endtask

  task automatic predict_item(input logic [REQ_W-1:0] req, input logic signed [SPEED_W-1:0] tgt,
                              input logic [DT_W-1:0] dt);
    ramp_result_t r;
    longint lim, delta, mag, fq, per;
    logic want_dir;
    r = '0;
    mag = 0;
    per = 0;
    if (req == REQ_START) begin
      if (enabled) r.status = 1'b1;
      else enabled = 1'b1;
    end else if (req == REQ_STOP) begin
      if (enabled) begin
        spd = 0;
        pulse_on = 1'b0;
        enabled = 1'b0;
      end
    end else if (req == REQ_BAD || !enabled) begin
      r.status = 1'b1;
    end else begin
      lim = (longint'(cfg_accel) * longint'(dt) * 256) / 1000000;
      delta = longint'(tgt) - spd;
      if (delta > lim) delta = lim;
      if (delta < -lim) delta = -lim;
      spd = spd + delta;
      if (spd > SPD_SAT) spd = SPD_SAT;
      if (spd < -SPD_SAT) spd = -SPD_SAT;
      want_dir = (spd < 0);
      mag = (spd < 0 ? -spd : spd) >>> 8;
      if (mag > longint'(cfg_max_rate)) mag = longint'(cfg_max_rate);
      if (mag < longint'(cfg_min_rate)) mag = 0;
      if (mag == 0) begin
        pulse_on = 1'b0;
      end else begin
        fq = mag << ((cfg_ms > MS_CAP) ? MS_CAP : cfg_ms);
        per = longint'(TICK_HZ) / fq;
        if (per == 0) per = 1;
        if (per > PER_CAP) per = PER_CAP;
        // pin only rewritten on a real direction change or the first move
        if (!dir_ok || dir_lvl != want_dir) begin
          dir_lvl = want_dir;
          dir_ok = 1'b1;
          r.written = 1'b1;
        end
        pulse_on = 1'b1;
      end
    end
    r.speed = spd[SPEED_W-1:0];
    r.rate = mag[RATE_W-1:0];
    r.period = per[PER_W-1:0];
    r.dir = dir_lvl;
    r.pulses = pulse_on;
    ramp_exp_q.push_back(r);
  endtask

  task automatic check_result(input logic [63:0] d, input logic st);
    ramp_result_t want;
    if (ramp_exp_q.size() == 0) begin
      report_mismatch("unexpected result", longint'(d), longint'(0));
    end else begin
      want = ramp_exp_q.pop_front();
      if (st !== want.status)
        report_mismatch("status", longint'(st), longint'(want.status));
      if (d[23:0] !== want.speed)
        report_mismatch("speed_now_q8", longint'(d[23:0]), longint'(want.speed));
      if (d[38:24] !== want.rate)
        report_mismatch("step_rate", longint'(d[38:24]), longint'(want.rate));
      if (d[58:39] !== want.period)
        report_mismatch("step_period", longint'(d[58:39]), longint'(want.period));
      if (d[59] !== want.dir)
        report_mismatch("direction", longint'(d[59]), longint'(want.dir));
      if (d[60] !== want.written)
        report_mismatch("direction_written", longint'(d[60]), longint'(want.written));
      if (d[61] !== want.pulses)
        report_mismatch("pulses_running", longint'(d[61]), longint'(want.pulses));
    end
    n_results++;
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      in_gap = 0;
    end else begin
      in_busy = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_item(s_axis_tuser_i, s_axis_tdata_i[23:0], s_axis_tdata_i[43:24]);
        n_accepted++;
        in_busy = 1'b0;
        in_gap = idle_len();
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (req_q.size() != 0) begin
          nxt = req_q.pop_front();
          s_axis_tuser_i <= nxt.req;
          s_axis_tdata_i <= {4'b0, nxt.dt, nxt.tgt};
          in_busy = 1'b1;
        end
      end
      s_axis_tvalid_i <= in_busy;
    end
  end

  // result monitor, ready drops at random points
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      out_stall = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) check_result(m_axis_tdata_o, m_axis_tuser_o);
      out_rdy = (out_stall == 0);
      if (out_stall > 0) out_stall--;
      else if ($urandom_range(0, 5) == 0) out_stall = idle_len();
      m_axis_tready_i <= out_rdy;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_item(input logic [REQ_W-1:0] req, input logic [SPEED_W-1:0] tgt,
                          input logic [DT_W-1:0] dt);
    ramp_req_t it;
    it.req = req;
    it.tgt = tgt;
    it.dt = dt;
    req_q.push_back(it);
    n_queued++;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (!(n_accepted == n_queued && ramp_exp_q.size() == 0));
  endtask

  // writes all four registers back to back; unused upper data bits are random
  task automatic write_config(input logic [RATE_W-1:0] mx, input logic [RATE_W-1:0] mn,
                              input logic [ACC_W-1:0] acc, input logic [MS_W-1:0] ms);
    logic [CFG_DATA_W-1:0] vals [4];
    cfg_e regs [4];
    int k;
    regs[0] = CFG_MAX_RATE;
    regs[1] = CFG_MIN_RATE;
    regs[2] = CFG_ACCEL;
    regs[3] = CFG_MICROSTEP;
    vals[0] = {1'($urandom), mx};
    vals[1] = {1'($urandom), mn};
    vals[2] = acc;
    vals[3] = {13'($urandom), ms};
    k = 0;
    cfg_addr_i <= regs[0];
    cfg_data_i <= vals[0];
    cfg_valid_i <= 1'b1;
    while (k < 4) begin
      @(posedge clk_i);
      if (cfg_ready_o) begin
        case (regs[k])
          CFG_MAX_RATE:  cfg_max_rate = vals[k][RATE_W-1:0];
          CFG_MIN_RATE:  cfg_min_rate = vals[k][RATE_W-1:0];
          CFG_ACCEL:     cfg_accel = vals[k][ACC_W-1:0];
          CFG_MICROSTEP: cfg_ms = vals[k][MS_W-1:0];
          default: ;
        endcase
        k++;
        if (k < 4) begin
          cfg_addr_i <= regs[k];
          cfg_data_i <= vals[k];
        end
      end
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic longint pick_target();
    longint span, v;
    int r;
    r = $urandom_range(0, 99);
    span = 0;
    if (r < 45) span = (longint'(cfg_max_rate) + 20) * 256;
    else if (r < 65) span = (longint'(cfg_min_rate) * 2 + 2) * 256;
    else if (r < 85) return longint'($signed(24'($urandom)));
    else begin
      case ($urandom_range(0, 2))
        0: return 8388607;
        1: return -8388608;
        default: return 0;
      endcase
    end
    v = longint'($urandom_range(0, 32'(2 * span))) - span;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v;
  endfunction

  function automatic logic [DT_W-1:0] pick_dt();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return DT_W'($urandom_range(1000, 20000));
    if (r < 75) return DT_W'($urandom_range(0, 999));
    if (r < 85) return DT_W'($urandom_range(0, 1000000));
    if (r < 95) return DT_W'($urandom);
    return r[0] ? 20'd1000000 : 20'hFFFFF;
  endfunction

  // mostly updates toward a target that moves now and then, so ramps play out
  task automatic gen_phase(input int n);
    longint tgt;
    int k, r;
    tgt = pick_target();
    add_item(REQ_START, 24'($urandom), 20'($urandom));
    for (k = 1; k < n; k++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 4) == 0) tgt = pick_target();
      if (r < 3) add_item(REQ_STOP, 24'($urandom), 20'($urandom));
      else if (r < 7) add_item(REQ_START, 24'($urandom), 20'($urandom));
      else if (r < 9) add_item(REQ_BAD, 24'($urandom), 20'($urandom));
      else add_item(REQ_UPDATE, 24'(tgt), pick_dt());
    end
  endtask

  initial begin
    logic [RATE_W-1:0] mx, mn;
    logic [ACC_W-1:0] acc;
    int p, r;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values: rejected requests, clamp, stop rate, turn around
    add_item(REQ_UPDATE, 24'd1000, 20'd1000);
    add_item(REQ_STOP, 24'd0, 20'd0);
    add_item(REQ_BAD, 24'd0, 20'd0);
    add_item(REQ_START, 24'd0, 20'd0);
    add_item(REQ_START, 24'd0, 20'd0);
    add_item(REQ_UPDATE, 24'h7FFFFF, 20'd1000000);
    add_item(REQ_UPDATE, 24'h800000, 20'd1000000);
    add_item(REQ_UPDATE, 24'h800000, 20'd0);
    add_item(REQ_UPDATE, 24'h800000, 20'hFFFFF);
    add_item(REQ_UPDATE, 24'd1000, 20'd1000000);
    add_item(REQ_BAD, 24'hFFFFFF, 20'hFFFFF);
    add_item(REQ_STOP, 24'd0, 20'd0);
    add_item(REQ_UPDATE, 24'd0, 20'd1000);
    wait_idle();

    // widest limits: speed saturation both ways, smallest nonzero rate
    write_config(15'd32767, 15'd1, 16'hFFFF, 3'd0);
    add_item(REQ_START, 24'd0, 20'd0);
    add_item(REQ_UPDATE, 24'h7FFFFF, 20'd1000000);
    add_item(REQ_UPDATE, 24'h800000, 20'hFFFFF);
    add_item(REQ_UPDATE, 24'd255, 20'hFFFFF);
    add_item(REQ_UPDATE, 24'd256, 20'd1000);
    add_item(REQ_STOP, 24'd0, 20'd0);
    wait_idle();

    // min above max: every speed stops the pulses; microstep code above five
    write_config(15'd200, 15'd500, 16'hFFFF, 3'd7);
    add_item(REQ_START, 24'd0, 20'd0);
    add_item(REQ_UPDATE, 24'h7FFFFF, 20'd500000);
    add_item(REQ_UPDATE, 24'hFFFFFF, 20'd20);

    for (p = 0; p < 8; p++) begin
      wait_idle();
      if (p == 0) begin
        write_config(15'd32767, 15'd1, 16'hFFFF, 3'd5);
      end else if (p == 1) begin
        write_config(15'd1, 15'd1, 16'd1, 3'd0);
      end else begin
        r = $urandom_range(0, 99);
        mx = (r < 50) ? 15'($urandom_range(50, 3000)) : 15'($urandom_range(1, 32767));
        r = $urandom_range(0, 99);
        if (r < 70) mn = 15'($urandom_range(1, 50));
        else if (r < 90) mn = 15'($urandom_range(1, mx));
        else mn = 15'($urandom_range(1, 32767));
        r = $urandom_range(0, 99);
        if (r < 50) acc = 16'($urandom_range(500, 20000));
        else if (r < 80) acc = 16'($urandom_range(1, 65535));
        else acc = 16'hFFFF;
        write_config(mx, mn, acc, 3'($urandom_range(0, 7)));
      end
      steady = (p % 4 == 3);
      gen_phase(125);
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
